[hdl/wmms_pkg.sv]
package wmms_pkg;

    localparam int QDEPTH = 16;
    localparam int QPW = $clog2(QDEPTH);

    localparam int THR_W = 16;
    localparam logic signed [THR_W-1:0] THR_RESET = 16'sd30;

    localparam int DAYF_W = 3;
    localparam int HOURF_W = 5;
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    localparam logic KIND_DAY = 1'b0;
    localparam logic KIND_WEEK = 1'b1;

endpackage

[hdl/windowed_min_max_mean_stats.sv]
// Windowed min/max/mean statistics. Takes one signed sample per beat, every cycle while o_stall is low, and
// groups samples into days of HOURS_PER_DAY and weeks of DAYS_PER_WINDOW days. The last
// sample of a day yields a daily result (max, min, mean truncated toward zero); the last
// sample of a week yields the daily result followed by the weekly result (max, min, mean,
// day and hour of the first weekly maximum, count of samples above the threshold), after
// which a fresh week starts. A sample runs through three pipeline registers (bias and
// reciprocal multiply, remainder fix-up, accumulate) so its results are written into a
// 16-deep result queue by the accumulate stage and then offered at its head. The means
// come from per-sample quotient/remainder accumulation, so no divider is present. o_stall
// rises only when the queue plus two slots for each sample in flight and two for the
// incoming sample would overflow; with the output side draining, the block sustains one
// sample per cycle. The threshold register resets to 30 and may be written whenever the
// block is idle.
module windowed_min_max_mean_stats
    import wmms_pkg::*;
#(
    parameter int HOURS_PER_DAY = 24,
    parameter int DAYS_PER_WINDOW = 7,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic signed [THR_W-1:0]        i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_kind,
    output logic [DAYF_W-1:0]              o_day_number,
    output logic signed [SAMPLE_WIDTH-1:0] o_peak_value,
    output logic signed [SAMPLE_WIDTH-1:0] o_trough_value,
    output logic signed [SAMPLE_WIDTH-1:0] o_mean_value,
    output logic [DAYF_W-1:0]              o_peak_day,
    output logic [HOURF_W-1:0]             o_peak_hour,
    output logic [CNT_W-1:0]               o_hot_count,
    output logic                           o_last_of_run
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int HW = $clog2(HOURS_PER_DAY);
    localparam int DW = (DAYS_PER_WINDOW > 1) ? $clog2(DAYS_PER_WINDOW) : 1;
    localparam int HD = HOURS_PER_DAY * DAYS_PER_WINDOW;
    localparam int LD = $clog2(HOURS_PER_DAY);
    localparam int LW = $clog2(HD);
    localparam int RDW = LD + 1;
    localparam int RWW = LW + 1;
    localparam int QW = SW + 2;
    localparam int PW = 2 * SW + 1;

    localparam logic [HW-1:0] HOUR_LAST = HW'(HOURS_PER_DAY - 1);
    localparam logic [DW-1:0] DAY_LAST = DW'(DAYS_PER_WINDOW - 1);

    // reciprocals: q = (u * M) >> S, exact for all SW-bit u
    localparam int SD = SW + LD;
    localparam int SWK = SW + LW;
    localparam logic [63:0] MD64 =
        ((64'd1 << SD) + 64'(HOURS_PER_DAY) - 64'd1) / 64'(HOURS_PER_DAY);
    localparam logic [63:0] MW64 = ((64'd1 << SWK) + 64'(HD) - 64'd1) / 64'(HD);
    localparam logic [SW:0] MD_C = MD64[SW:0];
    localparam logic [SW:0] MW_C = MW64[SW:0];

    localparam logic [SW+LD-1:0] DIV_D = (SW + LD)'(HOURS_PER_DAY);
    localparam logic [SW+LW-1:0] DIV_W = (SW + LW)'(HD);
    localparam logic [RDW-1:0] DIV_DR = RDW'(HOURS_PER_DAY);
    localparam logic [RWW-1:0] DIV_WR = RWW'(HD);

    // sample bias 2^(SW-1) split into quotient and remainder per divisor
    localparam logic [63:0] BIAS = 64'd1 << (SW - 1);
    localparam logic [63:0] QB_D64 = BIAS / 64'(HOURS_PER_DAY);
    localparam logic [63:0] RB_D64 = BIAS % 64'(HOURS_PER_DAY);
    localparam logic [63:0] QB_W64 = BIAS / 64'(HD);
    localparam logic [63:0] RB_W64 = BIAS % 64'(HD);
    localparam logic signed [QW-1:0] QB_D = QW'(QB_D64);
    localparam logic signed [QW-1:0] QB_W = QW'(QB_W64);
    localparam logic signed [RDW:0] RB_D = (RDW + 1)'(RB_D64);
    localparam logic signed [RWW:0] RB_W = (RWW + 1)'(RB_W64);

    localparam logic [QPW:0] QDEPTH_C = (QPW + 1)'(QDEPTH);

    typedef struct packed {
        logic                    kind;
        logic [DAYF_W-1:0]       day_number;
        logic signed [SW-1:0]    peak_value;
        logic signed [SW-1:0]    trough_value;
        logic signed [SW-1:0]    mean_value;
        logic [DAYF_W-1:0]       peak_day;
        logic [HOURF_W-1:0]      peak_hour;
        logic [CNT_W-1:0]        hot_count;
        logic                    last_of_run;
    } t_result;

    logic signed [THR_W-1:0] r_thr;

    // stage 1
    logic                 r1_valid;
    logic signed [SW-1:0] r1_sample;
    logic [SW-1:0]        u1;
    logic [PW-1:0]        prod_d, prod_w;

    // stage 2
    logic                 r2_valid;
    logic signed [SW-1:0] r2_sample;
    logic [SW-1:0]        r2_u;
    logic [PW-1:0]        r2_prod_d, r2_prod_w;
    logic [SW-1:0]        qu_d, qu_w;
    logic [SW+LD-1:0]     rem_full_d;
    logic [SW+LW-1:0]     rem_full_w;
    logic signed [RDW:0]  rs_raw_d;
    logic signed [RWW:0]  rs_raw_w;
    logic signed [QW-1:0] qs_d, qs_w;
    logic [RDW-1:0]       rs_d;
    logic [RWW-1:0]       rs_w;

    // stage 3
    logic                 r3_valid;
    logic signed [SW-1:0] r3_sample;
    logic signed [QW-1:0] r3_qs_d, r3_qs_w;
    logic [RDW-1:0]       r3_rs_d;
    logic [RWW-1:0]       r3_rs_w;

    // accumulators
    logic [HW-1:0]        r_hour, n_hour;
    logic [DW-1:0]        r_day, n_day;
    logic signed [SW-1:0] r_dmax, n_dmax, r_dmin, n_dmin;
    logic signed [SW-1:0] r_wmax, n_wmax, r_wmin, n_wmin;
    logic signed [QW-1:0] r_dq, n_dq, r_wq, n_wq;
    logic [RDW-1:0]       r_dr, n_dr;
    logic [RWW-1:0]       r_wr, n_wr;
    logic [DW-1:0]        r_pk_day, n_pk_day;
    logic [HW-1:0]        r_pk_hour, n_pk_hour;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    logic                 first_d, first_w, day_end, week_end;
    logic signed [QW-1:0] sum_dq, sum_wq, mean_dq, mean_wq;
    logic [RDW-1:0]       sum_dr;
    logic [RWW-1:0]       sum_wr;
    logic [CNT_W-1:0]     cnt_base;
    logic signed [32:0]   cmp_s, cmp_t;
    logic [31:0]          day_ext, pk_day_ext, pk_hour_ext;
    t_result              res_d, res_w;

    // result queue
    t_result              r_q [QDEPTH];
    logic [QPW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [QPW:0]         r_count;
    logic                 push_d, push_w, pop, in_accept;
    logic [1:0]           inflight;
    logic [QPW+2:0]       reserve;
    t_result              head;

    assign inflight = 2'(r1_valid) + 2'(r2_valid) + 2'(r3_valid);
    assign reserve = (QPW + 3)'(r_count) + (QPW + 3)'({inflight, 1'b0}) + (QPW + 3)'(2);
    assign o_stall = reserve > (QPW + 3)'(QDEPTH);
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // stage 1: bias to unsigned, multiply by reciprocals
    assign u1 = {~r1_sample[SW-1], r1_sample[SW-2:0]};
    assign prod_d = PW'(u1) * PW'(MD_C);
    assign prod_w = PW'(u1) * PW'(MW_C);

    // stage 2: quotient, remainder, remove bias
    always_comb begin
        qu_d = SW'(r2_prod_d >> SD);
        qu_w = SW'(r2_prod_w >> SWK);
        rem_full_d = (SW + LD)'(r2_u) - (SW + LD)'(qu_d) * DIV_D;
        rem_full_w = (SW + LW)'(r2_u) - (SW + LW)'(qu_w) * DIV_W;
        rs_raw_d = $signed({1'b0, RDW'(rem_full_d)}) - RB_D;
        rs_raw_w = $signed({1'b0, RWW'(rem_full_w)}) - RB_W;
        if (rs_raw_d < 0) begin
            rs_d = RDW'(rs_raw_d + $signed({1'b0, DIV_DR}));
            qs_d = $signed(QW'(qu_d)) - QB_D - QW'(1);
        end else begin
            rs_d = RDW'(rs_raw_d);
            qs_d = $signed(QW'(qu_d)) - QB_D;
        end
        if (rs_raw_w < 0) begin
            rs_w = RWW'(rs_raw_w + $signed({1'b0, DIV_WR}));
            qs_w = $signed(QW'(qu_w)) - QB_W - QW'(1);
        end else begin
            rs_w = RWW'(rs_raw_w);
            qs_w = $signed(QW'(qu_w)) - QB_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= in_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r1_sample <= i_sample;
        end
        r2_sample <= r1_sample;
        r2_u <= u1;
        r2_prod_d <= prod_d;
        r2_prod_w <= prod_w;
        r3_sample <= r2_sample;
        r3_qs_d <= qs_d;
        r3_qs_w <= qs_w;
        r3_rs_d <= rs_d;
        r3_rs_w <= rs_w;
    end

    // stage 3: accumulate and form results
    always_comb begin
        first_d = (r_hour == '0);
        first_w = first_d && (r_day == '0);
        day_end = (r_hour == HOUR_LAST);
        week_end = day_end && (r_day == DAY_LAST);
        cmp_s = 33'(r3_sample);
        cmp_t = 33'(r_thr);

        n_dmax = (first_d || r3_sample > r_dmax) ? r3_sample : r_dmax;
        n_dmin = (first_d || r3_sample < r_dmin) ? r3_sample : r_dmin;
        n_wmin = (first_w || r3_sample < r_wmin) ? r3_sample : r_wmin;
        if (first_w) begin
            n_wmax = r3_sample;
            n_pk_day = '0;
            n_pk_hour = '0;
        end else if (r3_sample > r_wmax) begin
            n_wmax = r3_sample;
            n_pk_day = r_day;
            n_pk_hour = r_hour;
        end else begin
            n_wmax = r_wmax;
            n_pk_day = r_pk_day;
            n_pk_hour = r_pk_hour;
        end

        cnt_base = first_w ? '0 : r_cnt;
        n_cnt = (cmp_s > cmp_t && cnt_base != CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;

        sum_dq = (first_d ? '0 : r_dq) + r3_qs_d;
        sum_dr = (first_d ? '0 : r_dr) + r3_rs_d;
        sum_wq = (first_w ? '0 : r_wq) + r3_qs_w;
        sum_wr = (first_w ? '0 : r_wr) + r3_rs_w;
        if (sum_dr >= DIV_DR) begin
            n_dr = sum_dr - DIV_DR;
            n_dq = sum_dq + QW'(1);
        end else begin
            n_dr = sum_dr;
            n_dq = sum_dq;
        end
        if (sum_wr >= DIV_WR) begin
            n_wr = sum_wr - DIV_WR;
            n_wq = sum_wq + QW'(1);
        end else begin
            n_wr = sum_wr;
            n_wq = sum_wq;
        end
        // floor to truncation toward zero
        mean_dq = (n_dq < 0 && n_dr != '0) ? n_dq + QW'(1) : n_dq;
        mean_wq = (n_wq < 0 && n_wr != '0) ? n_wq + QW'(1) : n_wq;

        if (day_end) begin
            n_hour = '0;
            n_day = week_end ? '0 : r_day + DW'(1);
        end else begin
            n_hour = r_hour + HW'(1);
            n_day = r_day;
        end

        day_ext = 32'(r_day);
        pk_day_ext = 32'(n_pk_day);
        pk_hour_ext = 32'(n_pk_hour);

        res_d.kind = KIND_DAY;
        res_d.day_number = day_ext[DAYF_W-1:0];
        res_d.peak_value = n_dmax;
        res_d.trough_value = n_dmin;
        res_d.mean_value = SW'(mean_dq);
        res_d.peak_day = '0;
        res_d.peak_hour = '0;
        res_d.hot_count = '0;
        res_d.last_of_run = !week_end;

        res_w.kind = KIND_WEEK;
        res_w.day_number = day_ext[DAYF_W-1:0];
        res_w.peak_value = n_wmax;
        res_w.trough_value = n_wmin;
        res_w.mean_value = SW'(mean_wq);
        res_w.peak_day = pk_day_ext[DAYF_W-1:0];
        res_w.peak_hour = pk_hour_ext[HOURF_W-1:0];
        res_w.hot_count = n_cnt;
        res_w.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour <= '0;
            r_day <= '0;
        end else if (r3_valid) begin
            r_hour <= n_hour;
            r_day <= n_day;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_valid) begin
            r_dmax <= n_dmax;
            r_dmin <= n_dmin;
            r_wmax <= n_wmax;
            r_wmin <= n_wmin;
            r_dq <= n_dq;
            r_dr <= n_dr;
            r_wq <= n_wq;
            r_wr <= n_wr;
            r_pk_day <= n_pk_day;
            r_pk_hour <= n_pk_hour;
            r_cnt <= n_cnt;
        end
    end

    // result queue
    assign push_d = r3_valid && day_end;
    assign push_w = r3_valid && week_end;
    assign o_valid = (r_count != '0);
    assign pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPW'(push_d) + QPW'(push_w);
            r_rd_ptr <= r_rd_ptr + QPW'(pop);
            r_count <= r_count + (QPW + 1)'(push_d) + (QPW + 1)'(push_w) - (QPW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_d) begin
            r_q[r_wr_ptr] <= res_d;
        end
        if (push_w) begin
            r_q[r_wr_ptr + QPW'(1)] <= res_w;
        end
    end

    assign head = r_q[r_rd_ptr];
    assign o_kind = head.kind;
    assign o_day_number = head.day_number;
    assign o_peak_value = head.peak_value;
    assign o_trough_value = head.trough_value;
    assign o_mean_value = head.mean_value;
    assign o_peak_day = head.peak_day;
    assign o_peak_hour = head.peak_hour;
    assign o_hot_count = head.hot_count;
    assign o_last_of_run = head.last_of_run;

    // queue never overcommitted: stored results plus worst case in flight fit
    a_reserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + {inflight, 1'b0}) <= QDEPTH_C)
        else $error("result queue overcommitted");

    // a weekly result is always the last beat of its sample
    a_week_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && o_kind == KIND_WEEK |-> o_last_of_run)
        else $error("weekly result not last of run");

    // week end only ever pushes together with its daily result
    a_week_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_w |-> push_d)
        else $error("weekly result without daily result");

    // position counters advance only on a sample leaving stage 3
    a_hour_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r3_valid |=> $stable(r_hour) && $stable(r_day))
        else $error("position moved without a sample");

endmodule
